// ----- hdl/bbox_acc_pkg.sv -----
package bbox_acc_pkg;

    localparam int COORD_BITS = 32;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam longint CoordMax  = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    localparam longint HalfSpan  = 64'sd1800000000;
    localparam longint SpanMax64 = (HalfSpan > CoordMax) ? CoordMax : HalfSpan;
    localparam longint SpanMin64 = (HalfSpan > CoordMax) ? (-CoordMax - 64'sd1) : -HalfSpan;

    localparam coord_t FULL_SPAN_MIN = SpanMin64[COORD_BITS-1:0];
    localparam coord_t FULL_SPAN_MAX = SpanMax64[COORD_BITS-1:0];

    localparam logic REG_ACCUMULATE_ENABLE = 1'b0;
    localparam logic REG_ANTIMERIDIAN_MODE = 1'b1;

    typedef struct packed {
        logic   box_valid;
        logic   box_is_3d;
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        coord_t min_z;
        coord_t max_z;
    } result_t;

endpackage

// ----- hdl/bbox_accumulator_antimeridian.sv -----
// Layer bounding box accumulator. Each accepted beat carries one feature
// envelope and yields exactly one result beat holding the layer box after
// that envelope has been folded in. The merge is a single pass of compares
// and muxes against the box registers, so one beat is accepted every cycle
// when in_stall is low; its result is registered. A two-entry output buffer
// lets input beats keep flowing while a result waits on out_stall; in_stall
// rises only once both entries are full. Configuration must be written while
// no beats are in flight. While the box is empty every coordinate reads zero.
module bbox_accumulator_antimeridian
    import bbox_acc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,

    input  logic   cfg_wr_en,
    input  logic   cfg_index,
    input  logic   cfg_data,

    input  logic   in_valid,
    output logic   in_stall,
    input  logic   has_geometry,
    input  logic   has_z,
    input  coord_t in_min_x,
    input  coord_t in_max_x,
    input  coord_t in_min_y,
    input  coord_t in_max_y,
    input  coord_t in_min_z,
    input  coord_t in_max_z,

    output logic   out_valid,
    input  logic   out_stall,
    output logic   box_valid,
    output logic   box_is_3d,
    output coord_t out_min_x,
    output coord_t out_max_x,
    output coord_t out_min_y,
    output coord_t out_max_y,
    output coord_t out_min_z,
    output coord_t out_max_z
);

    logic    accumulate_enable_reg;
    logic    antimeridian_mode_reg;

    logic    acc_valid_reg, acc_valid_next;
    logic    acc_3d_reg, acc_3d_next;
    coord_t  acc_min_x_reg, acc_min_x_next;
    coord_t  acc_max_x_reg, acc_max_x_next;
    coord_t  acc_min_y_reg, acc_min_y_next;
    coord_t  acc_max_y_reg, acc_max_y_next;
    coord_t  acc_min_z_reg, acc_min_z_next;
    coord_t  acc_max_z_reg, acc_max_z_next;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    result_t result_next;

    logic    accept;
    logic    take;
    logic    update;
    logic    e_cross;
    logic    l_cross;
    coord_t  x_min_merged;
    coord_t  x_max_merged;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take     = main_valid_reg && !out_stall;
    assign update   = accept && accumulate_enable_reg && has_geometry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accumulate_enable_reg <= 1'b0;
            antimeridian_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ACCUMULATE_ENABLE: accumulate_enable_reg <= cfg_data;
                REG_ANTIMERIDIAN_MODE: antimeridian_mode_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Crossing-aware X merge against the current layer box.
    always_comb
    begin
        e_cross      = in_min_x > in_max_x;
        l_cross      = acc_min_x_reg > acc_max_x_reg;
        x_min_merged = acc_min_x_reg;
        x_max_merged = acc_max_x_reg;
        if (e_cross)
        begin
            if (l_cross)
            begin
                x_min_merged = (in_min_x < acc_min_x_reg) ? in_min_x : acc_min_x_reg;
                x_max_merged = (in_max_x > acc_max_x_reg) ? in_max_x : acc_max_x_reg;
            end
            else if (acc_min_x_reg > 0)
            begin
                x_min_merged = (in_min_x < acc_min_x_reg) ? in_min_x : acc_min_x_reg;
                x_max_merged = in_max_x;
            end
            else if (acc_max_x_reg < 0)
            begin
                x_min_merged = in_min_x;
                x_max_merged = (in_max_x > acc_max_x_reg) ? in_max_x : acc_max_x_reg;
            end
            else
            begin
                x_min_merged = FULL_SPAN_MIN;
                x_max_merged = FULL_SPAN_MAX;
            end
        end
        else if (l_cross)
        begin
            if (in_min_x > 0)
            begin
                x_min_merged = (in_min_x < acc_min_x_reg) ? in_min_x : acc_min_x_reg;
            end
            else if (in_max_x < 0)
            begin
                x_max_merged = (in_max_x > acc_max_x_reg) ? in_max_x : acc_max_x_reg;
            end
            else
            begin
                x_min_merged = FULL_SPAN_MIN;
                x_max_merged = FULL_SPAN_MAX;
            end
        end
        else
        begin
            x_min_merged = (in_min_x < acc_min_x_reg) ? in_min_x : acc_min_x_reg;
            x_max_merged = (in_max_x > acc_max_x_reg) ? in_max_x : acc_max_x_reg;
        end
    end

    always_comb
    begin
        acc_valid_next = acc_valid_reg;
        acc_3d_next    = acc_3d_reg;
        acc_min_x_next = acc_min_x_reg;
        acc_max_x_next = acc_max_x_reg;
        acc_min_y_next = acc_min_y_reg;
        acc_max_y_next = acc_max_y_reg;
        acc_min_z_next = acc_min_z_reg;
        acc_max_z_next = acc_max_z_reg;
        if (update)
        begin
            acc_valid_next = 1'b1;
            acc_3d_next    = acc_3d_reg || has_z;
            if (!acc_valid_reg)
            begin
                acc_min_x_next = in_min_x;
                acc_max_x_next = in_max_x;
                acc_min_y_next = in_min_y;
                acc_max_y_next = in_max_y;
                acc_min_z_next = in_min_z;
                acc_max_z_next = in_max_z;
            end
            else
            begin
                if (antimeridian_mode_reg)
                begin
                    acc_min_x_next = x_min_merged;
                    acc_max_x_next = x_max_merged;
                end
                else
                begin
                    acc_min_x_next = (in_min_x < acc_min_x_reg) ? in_min_x : acc_min_x_reg;
                    acc_max_x_next = (in_max_x > acc_max_x_reg) ? in_max_x : acc_max_x_reg;
                    acc_min_z_next = (in_min_z < acc_min_z_reg) ? in_min_z : acc_min_z_reg;
                    acc_max_z_next = (in_max_z > acc_max_z_reg) ? in_max_z : acc_max_z_reg;
                end
                acc_min_y_next = (in_min_y < acc_min_y_reg) ? in_min_y : acc_min_y_reg;
                acc_max_y_next = (in_max_y > acc_max_y_reg) ? in_max_y : acc_max_y_reg;
            end
        end

        result_next.box_valid = acc_valid_next;
        result_next.box_is_3d = acc_valid_next && acc_3d_next;
        result_next.min_x     = acc_valid_next ? acc_min_x_next : '0;
        result_next.max_x     = acc_valid_next ? acc_max_x_next : '0;
        result_next.min_y     = acc_valid_next ? acc_min_y_next : '0;
        result_next.max_y     = acc_valid_next ? acc_max_y_next : '0;
        result_next.min_z     = acc_valid_next ? acc_min_z_next : '0;
        result_next.max_z     = acc_valid_next ? acc_max_z_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            acc_3d_reg    <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= acc_valid_next;
            acc_3d_reg    <= acc_3d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_min_x_reg <= acc_min_x_next;
        acc_max_x_reg <= acc_max_x_next;
        acc_min_y_reg <= acc_min_y_next;
        acc_max_y_reg <= acc_max_y_next;
        acc_min_z_reg <= acc_min_z_next;
        acc_max_z_reg <= acc_max_z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (accept)
            begin
                main_reg <= result_next;
            end
        end
        else if (accept)
        begin
            skid_reg <= result_next;
        end
    end

    assign out_valid = main_valid_reg;
    assign box_valid = main_reg.box_valid;
    assign box_is_3d = main_reg.box_is_3d;
    assign out_min_x = main_reg.min_x;
    assign out_max_x = main_reg.max_x;
    assign out_min_y = main_reg.min_y;
    assign out_max_y = main_reg.max_y;
    assign out_min_z = main_reg.min_z;
    assign out_max_z = main_reg.max_z;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while output entry is empty");

    a_box_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid_reg |=> acc_valid_reg)
        else $error("layer box lost its valid flag");

    a_empty_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !box_valid) |-> (out_min_x == '0 && out_max_x == '0 && !box_is_3d))
        else $error("empty box reports nonzero fields");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!accumulate_enable_reg && !cfg_wr_en) |=> $stable(acc_valid_reg))
        else $error("box changed while accumulation disabled");

endmodule

// ----- tb/bbox_accumulator_antimeridian_tb.sv -----
module bbox_accumulator_antimeridian_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef bbox_acc_pkg::coord_t  coord_t;
    typedef bbox_acc_pkg::result_t result_t;

    localparam int     ITEM_COUNT     = 1550;
    localparam int     QUIET_TAIL     = 200;
    localparam int     HOLD_AFTER     = 500;
    localparam int     HOLD_CYCLES    = 60;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     PRINT_LIMIT    = 40;
    localparam coord_t SPAN_EDGE      = 32'sd1800000000;
    localparam coord_t COORD_LO       = {1'b1, 31'd0};
    localparam coord_t COORD_HI       = {1'b0, {31{1'b1}}};

    typedef struct packed {
        logic   has_geometry;
        logic   has_z;
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        coord_t min_z;
        coord_t max_z;
    } envelope_t;

    class layer_box_tracker;
        bit      enable;
        bit      crossing_rules;
        bit      box_held;
        bit      saw_z;
        coord_t  lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
        result_t pending_boxes[$];
        int      beats_checked;
        int      errors;

        function void set_config(bit en, bit am);
            enable         = en;
            crossing_rules = am;
        endfunction

        function coord_t lower(coord_t a, coord_t b);
            return (a < b) ? a : b;
        endfunction

        function coord_t upper(coord_t a, coord_t b);
            return (a > b) ? a : b;
        endfunction

        // A box whose min_x exceeds its max_x wraps through 180 degrees.
        function void merge_x_crossing(coord_t e_lo, coord_t e_hi);
            bit e_cross;
            bit l_cross;
            e_cross = e_lo > e_hi;
            l_cross = lo_x > hi_x;
            if (e_cross == l_cross) begin
                lo_x = lower(lo_x, e_lo);
                hi_x = upper(hi_x, e_hi);
            end
            else if (e_cross && lo_x > 0) begin
                lo_x = lower(lo_x, e_lo);
                hi_x = e_hi;
            end
            else if (e_cross && hi_x < 0) begin
                hi_x = upper(hi_x, e_hi);
                lo_x = e_lo;
            end
            else if (!e_cross && e_lo > 0) begin
                lo_x = lower(lo_x, e_lo);
            end
            else if (!e_cross && e_hi < 0) begin
                hi_x = upper(hi_x, e_hi);
            end
            else begin
                lo_x = -SPAN_EDGE;
                hi_x = SPAN_EDGE;
            end
        endfunction

        function void note_envelope(envelope_t e);
            result_t want;
            if (enable && e.has_geometry) begin
                if (e.has_z)
                    saw_z = 1'b1;
                if (!box_held) begin
                    lo_x = e.min_x;
                    hi_x = e.max_x;
                    lo_y = e.min_y;
                    hi_y = e.max_y;
                    lo_z = e.min_z;
                    hi_z = e.max_z;
                    box_held = 1'b1;
                end
                else begin
                    if (crossing_rules) begin
                        merge_x_crossing(e.min_x, e.max_x);
                    end
                    else begin
                        lo_x = lower(lo_x, e.min_x);
                        hi_x = upper(hi_x, e.max_x);
                        lo_z = lower(lo_z, e.min_z);
                        hi_z = upper(hi_z, e.max_z);
                    end
                    lo_y = lower(lo_y, e.min_y);
                    hi_y = upper(hi_y, e.max_y);
                end
            end
            want = '0;
            if (box_held)
                want = {1'b1, saw_z, lo_x, hi_x, lo_y, hi_y, lo_z, hi_z};
            pending_boxes.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("ERROR: %s", msg);
        endtask

        task check_box(result_t got);
            result_t            want;
            logic signed [63:0] got_f [8];
            logic signed [63:0] want_f [8];
            string              names [8];
            beats_checked++;
            if (pending_boxes.size() == 0) begin
                report_mismatch($sformatf("result beat %0d arrived with no envelope pending",
                                          beats_checked));
                return;
            end
            want   = pending_boxes.pop_front();
            names  = '{"box_valid", "box_is_3d", "out_min_x", "out_max_x",
                       "out_min_y", "out_max_y", "out_min_z", "out_max_z"};
            got_f  = '{got.box_valid, got.box_is_3d, got.min_x, got.max_x,
                       got.min_y, got.max_y, got.min_z, got.max_z};
            want_f = '{want.box_valid, want.box_is_3d, want.min_x, want.max_x,
                       want.min_y, want.max_y, want.min_z, want.max_z};
            for (int i = 0; i < 8; i++) begin
                if (got_f[i] !== want_f[i])
                    report_mismatch($sformatf("result beat %0d: %s is %0d, expected %0d",
                                              beats_checked, names[i], got_f[i], want_f[i]));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_index = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    envelope_t beat_in   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    logic      box_valid;
    logic      box_is_3d;
    coord_t    out_min_x, out_max_x, out_min_y, out_max_y, out_min_z, out_max_z;
    result_t   observed_box;

    layer_box_tracker tracker = new();
    int        items_sent = 0;
    bit        quiet      = 1'b0;

    wire in_beat  = in_valid && !in_stall;
    wire out_beat = out_valid && !out_stall;

    assign observed_box = {box_valid, box_is_3d, out_min_x, out_max_x,
                           out_min_y, out_max_y, out_min_z, out_max_z};

    bbox_accumulator_antimeridian u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .has_geometry (beat_in.has_geometry),
        .has_z        (beat_in.has_z),
        .in_min_x     (beat_in.min_x),
        .in_max_x     (beat_in.max_x),
        .in_min_y     (beat_in.min_y),
        .in_max_y     (beat_in.max_y),
        .in_min_z     (beat_in.min_z),
        .in_max_z     (beat_in.max_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .box_valid    (box_valid),
        .box_is_3d    (box_is_3d),
        .out_min_x    (out_min_x),
        .out_max_x    (out_max_x),
        .out_min_y    (out_min_y),
        .out_max_y    (out_max_y),
        .out_min_z    (out_min_z),
        .out_max_z    (out_max_z)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && in_beat)
            tracker.note_envelope(beat_in);
        if (rst_n && out_beat)
            tracker.check_box(observed_box);
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            idle_cycles = (in_beat || out_beat) ? 0 : idle_cycles + 1;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // One long hold-off fills the output buffer so that in_stall must rise.
    initial begin : receiver
        bit held_once;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (!held_once && tracker.beats_checked >= HOLD_AFTER) begin
                held_once = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(envelope_t e);
        in_valid <= 1'b1;
        beat_in  <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic settle_box();
        in_valid <= 1'b0;
        while (tracker.beats_checked != items_sent)
            @(posedge clk);
    endtask

    task automatic configure(bit en, bit am);
        cfg_wr_en <= 1'b1;
        cfg_index <= bbox_acc_pkg::REG_ACCUMULATE_ENABLE;
        cfg_data  <= en;
        @(posedge clk);
        cfg_index <= bbox_acc_pkg::REG_ANTIMERIDIAN_MODE;
        cfg_data  <= am;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_config(en, am);
    endtask

    function automatic envelope_t envelope(bit geom, bit z, coord_t x0, coord_t x1,
                                           coord_t y0, coord_t y1, coord_t z0, coord_t z1);
        return {geom, z, x0, x1, y0, y1, z0, z1};
    endfunction

    // Narrow values keep the box small enough to revisit every crossing rule;
    // wide values reach the edges of the coordinate range.
    function automatic coord_t rand_coord(bit wide);
        int pick;
        pick = $urandom_range(0, 15);
        if (!wide || pick < 8)
            return coord_t'(int'($urandom_range(0, 4000)) - 2000);
        if (pick < 11)
            return (pick[0] ? SPAN_EDGE : -SPAN_EDGE)
                   + coord_t'(int'($urandom_range(0, 200)) - 100);
        if (pick == 11)
            return $urandom_range(0, 1) ? COORD_HI : COORD_LO;
        return coord_t'($urandom());
    endfunction

    function automatic envelope_t rand_envelope(bit wide);
        envelope_t e;
        coord_t    shift;
        case ($urandom_range(0, 2))
            0:       shift = -3000;
            1:       shift = 0;
            default: shift = 3000;
        endcase
        e.has_geometry = $urandom_range(0, 7) != 0;
        e.has_z        = 1'($urandom_range(0, 1));
        e.min_x        = rand_coord(wide) + shift;
        e.max_x        = rand_coord(wide) + shift;
        e.min_y        = rand_coord(wide);
        e.max_y        = rand_coord(wide);
        e.min_z        = rand_coord(wide);
        e.max_z        = rand_coord(wide);
        return e;
    endfunction

    initial begin : stimulus
        int random_sent;
        int phase_len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Accumulation is off after reset, so the box must read empty.
        send_beat(envelope(1'b1, 1'b1, COORD_HI, COORD_LO, COORD_LO, COORD_HI,
                           COORD_HI, COORD_LO));
        send_beat(envelope(1'b1, 1'b0, -5, 5, -5, 5, -5, 5));
        settle_box();
        configure(1'b1, 1'b1);
        send_beat(envelope(1'b0, 1'b1, 7, 8, 9, 10, 11, 12));
        send_beat(envelope(1'b1, 1'b0, 100, 200, 10, 20, 5, 6));
        send_beat(envelope(1'b1, 1'b1, 1000, -1000, -30, 40, 1, 9));
        send_beat(envelope(1'b1, 1'b0, 50, 60, 0, 0, 0, 0));
        send_beat(envelope(1'b1, 1'b0, -500, -300, 15, 15, 0, 0));
        send_beat(envelope(1'b1, 1'b1, 20, -100, 25, -25, 0, 0));
        settle_box();
        configure(1'b1, 1'b0);
        send_beat(envelope(1'b1, 1'b0, -50, -40, -60, -55, -7, 100));
        settle_box();
        configure(1'b1, 1'b1);
        send_beat(envelope(1'b1, 1'b0, 30, -60, 0, 0, 0, 0));
        send_beat(envelope(1'b1, 1'b0, -5, 5, 0, 0, 0, 0));
        send_beat(envelope(1'b1, 1'b1, 1700000000, -1700000000, 0, 0, 0, 0));
        send_beat(envelope(1'b1, 1'b0, COORD_LO, COORD_HI, 0, 0, COORD_LO, COORD_HI));
        send_beat(envelope(1'b1, 1'b0, 10, -10, 0, 0, 0, 0));
        settle_box();
        configure(1'b1, 1'b0);
        send_beat(envelope(1'b1, 1'b1, COORD_HI, COORD_LO, COORD_HI, COORD_LO,
                           COORD_HI, COORD_LO));
        send_beat(envelope(1'b0, 1'b1, COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                           COORD_LO, COORD_HI));
        settle_box();
        configure(1'b0, 1'b1);
        send_beat(envelope(1'b1, 1'b1, COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                           COORD_LO, COORD_HI));

        random_sent = 0;
        while (random_sent < ITEM_COUNT) begin
            settle_box();
            configure($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
            phase_len = $urandom_range(40, 160);
            for (int i = 0; i < phase_len && random_sent < ITEM_COUNT; i++) begin
                quiet = random_sent >= ITEM_COUNT - QUIET_TAIL;
                send_beat(rand_envelope(random_sent >= ITEM_COUNT / 2));
                random_sent++;
            end
        end

        settle_box();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_boxes.size() != 0)
            tracker.report_mismatch($sformatf("%0d envelopes never produced a result beat",
                                              tracker.pending_boxes.size()));
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
